// File: hdl/dit_pkg.sv
// Shared constants, codes and types for the disjoint interval table.
`default_nettype none

package dit_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VAL_W    = 32;
    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = 2 * VAL_W + TAG_W;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int RES_W     = 3 + 1 + 2 * VAL_W + TAG_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_RANGE = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_FINISH
    } fsm_e;

    typedef struct packed {
        logic [TAG_W-1:0] owner;
        logic [VAL_W-1:0] high;
        logic [VAL_W-1:0] low;
    } entry_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
        entry_t               data;
    } ram_wr_t;

endpackage

`default_nettype wire

// File: hdl/dit_ram.sv
// Single-port-write, single-port-read entry memory with a registered read.
`default_nettype none

module dit_ram (
    input  wire logic                        aclk,
    input  wire dit_pkg::ram_wr_t            wr,
    input  wire logic                        rd_en,
    input  wire logic [dit_pkg::IDX_W-1:0]   rd_addr,
    output dit_pkg::entry_t                  rd_data
);

    dit_pkg::entry_t entry_mem [dit_pkg::CAPACITY];
    dit_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/disjoint_interval_table_core.sv
// Top level of the disjoint interval table: request decode, table scan and result register.
//
// Keeps up to 64 disjoint closed ranges, each with a 16-bit owner tag.
// Requests arrive on the s_ channel: s_tuser carries the request kind
// (insert, remove, search lowest overlap) and s_tdata the range start,
// range count and owner tag. Every request yields exactly one result on
// the m_ channel: a status code and, for a search that found a range,
// its bounds and tag.
// A well-formed request is answered by a scan of all entries of the
// entry memory, one entry per cycle through its single read port. A
// malformed request (zero count, range past the top of the 32-bit
// space, or an unused kind) is answered without a scan. The block takes
// the next request only after the result is in the output register.
// The result sits in an output register; a stalled receiver holds it
// there while the next request is already taken and scanned. Only when
// a second result is ready before the first one leaves does the block
// wait.
// Reset clears all valid bits and the entry count; the table is then
// empty and ready at once, with no clearing pass.
`default_nettype none

module disjoint_interval_table_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] range_start, [63:32] range_count, [79:64] owner_tag
    input  wire logic [dit_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  wire logic [dit_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] status, [3] hit, [35:4] hit_low, [67:36] hit_high, [83:68] hit_tag
    output logic [dit_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int VW = dit_pkg::VAL_W;
    localparam int TW = dit_pkg::TAG_W;
    localparam int IW = dit_pkg::IDX_W;
    localparam int CW = dit_pkg::CNT_W;
    localparam int M_TDATA_W = dit_pkg::M_TDATA_W;

    dit_pkg::fsm_e                  state_reg, state_next;
    logic [1:0]                     req_reg, req_next;
    logic                           bad_reg, bad_next;
    logic [VW-1:0]                  qlow_reg, qlow_next;
    logic [VW-1:0]                  qhigh_reg, qhigh_next;
    logic [TW-1:0]                  tag_reg, tag_next;
    logic [IW-1:0]                  scan_reg, scan_next;
    logic                           pend_reg, pend_next;
    logic [IW-1:0]                  pidx_reg, pidx_next;
    logic                           found_reg, found_next;
    dit_pkg::entry_t                best_reg, best_next;
    logic                           match_reg, match_next;
    logic [IW-1:0]                  midx_reg, midx_next;
    logic                           free_reg, free_next;
    logic [IW-1:0]                  fidx_reg, fidx_next;
    logic [dit_pkg::CAPACITY-1:0]   valid_reg, valid_next;
    logic [CW-1:0]                  total_reg, total_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [dit_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    dit_pkg::ram_wr_t               ram_wr;
    logic                           ram_rd_en;
    dit_pkg::entry_t                ram_rd;

    logic                           s_accept;
    logic [VW:0]                    in_sum;
    logic [VW-1:0]                  in_start, in_count, in_end;
    logic                           in_bad;
    logic                           ent_valid, ent_overlap, ent_exact;
    logic                           out_free;
    dit_pkg::status_e               status;
    logic                           hit;
    dit_pkg::entry_t                hit_ent;

    dit_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_reg),
        .rd_data (ram_rd)
    );

    assign s_tready = (state_reg == dit_pkg::FSM_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // The last value of the range, and the check that it stays within 32 bits.
    assign in_start = s_tdata[VW-1:0];
    assign in_count = s_tdata[2*VW-1:VW];
    assign in_sum   = {1'b0, in_start} + {1'b0, in_count};
    assign in_end   = in_start + in_count - VW'(1);
    assign in_bad   = (in_count == '0) || (in_sum > {1'b1, {VW{1'b0}}}) ||
                      (s_tuser == dit_pkg::REQ_UNUSED);

    // Compare the entry that left the memory in this cycle with the query.
    assign ent_valid   = valid_reg[pidx_reg];
    assign ent_overlap = pend_reg && ent_valid &&
                         (ram_rd.low <= qhigh_reg) && (qlow_reg <= ram_rd.high);
    assign ent_exact   = pend_reg && ent_valid &&
                         (ram_rd.low == qlow_reg) && (ram_rd.high == qhigh_reg);

    always_comb begin
        status  = dit_pkg::ST_OK;
        hit     = 1'b0;
        hit_ent = '0;
        if (bad_reg) begin
            status = dit_pkg::ST_BAD_RANGE;
        end else begin
            case (req_reg)
                dit_pkg::REQ_INSERT: begin
                    if (found_reg) begin
                        status = dit_pkg::ST_OVERLAP;
                    end else if (total_reg >= CW'(dit_pkg::CAPACITY) || !free_reg) begin
                        status = dit_pkg::ST_FULL;
                    end
                end
                dit_pkg::REQ_REMOVE: begin
                    if (!match_reg) begin
                        status = dit_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                    if (found_reg) begin
                        hit     = 1'b1;
                        hit_ent = best_reg;
                    end else begin
                        status = dit_pkg::ST_NOT_FOUND;
                    end
                end
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        bad_next      = bad_reg;
        qlow_next     = qlow_reg;
        qhigh_next    = qhigh_reg;
        tag_next      = tag_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pidx_next     = scan_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        match_next    = match_reg;
        midx_next     = midx_reg;
        free_next     = free_reg;
        fidx_next     = fidx_reg;
        valid_next    = valid_reg;
        total_next    = total_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_rd_en     = 1'b0;
        ram_wr.en     = 1'b0;
        ram_wr.addr   = fidx_reg;
        ram_wr.data   = '{owner: tag_reg, high: qhigh_reg, low: qlow_reg};

        // Fold the entry read in the previous cycle into the running results.
        if (ent_overlap && (!found_reg || ram_rd.low < best_reg.low)) begin
            found_next = 1'b1;
            best_next  = ram_rd;
        end
        if (ent_exact && !match_reg) begin
            match_next = 1'b1;
            midx_next  = pidx_reg;
        end
        if (pend_reg && !ent_valid && !free_reg) begin
            free_next = 1'b1;
            fidx_next = pidx_reg;
        end

        unique case (state_reg)
            dit_pkg::FSM_IDLE: begin
                if (s_accept) begin
                    req_next   = s_tuser;
                    bad_next   = in_bad;
                    qlow_next  = in_start;
                    qhigh_next = in_end;
                    tag_next   = s_tdata[2*VW+TW-1:2*VW];
                    scan_next  = '0;
                    found_next = 1'b0;
                    match_next = 1'b0;
                    free_next  = 1'b0;
                    state_next = in_bad ? dit_pkg::FSM_FINISH : dit_pkg::FSM_SCAN;
                end
            end
            dit_pkg::FSM_SCAN: begin
                ram_rd_en = 1'b1;
                pend_next = 1'b1;
                scan_next = scan_reg + IW'(1);
                if (scan_reg == IW'(dit_pkg::CAPACITY - 1)) begin
                    scan_next  = '0;
                    state_next = dit_pkg::FSM_DRAIN;
                end
            end
            dit_pkg::FSM_DRAIN: begin
                state_next = dit_pkg::FSM_FINISH;
            end
            dit_pkg::FSM_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({hit_ent.owner, hit_ent.high, hit_ent.low,
                                               hit, status});
                    state_next    = dit_pkg::FSM_IDLE;
                    if (!bad_reg && status == dit_pkg::ST_OK) begin
                        if (req_reg == dit_pkg::REQ_INSERT) begin
                            ram_wr.en            = 1'b1;
                            valid_next[fidx_reg] = 1'b1;
                            total_next           = total_reg + CW'(1);
                        end else if (req_reg == dit_pkg::REQ_REMOVE) begin
                            valid_next[midx_reg] = 1'b0;
                            total_next           = total_reg - CW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = dit_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dit_pkg::FSM_IDLE;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            scan_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
            scan_reg     <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        bad_reg     <= bad_next;
        qlow_reg    <= qlow_next;
        qhigh_reg   <= qhigh_next;
        tag_reg     <= tag_next;
        pidx_reg    <= pidx_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        match_reg   <= match_next;
        midx_reg    <= midx_next;
        free_reg    <= free_next;
        fidx_reg    <= fidx_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// File: hdl/dit_checker.sv
// Port-level assertions for the disjoint interval table, bound to its top level.
`default_nettype none

module dit_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [dit_pkg::M_TDATA_W-1:0]   m_tdata
);

    // A stalled result keeps its value until it is taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: the block is busy right after taking one.
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a request is in progress");

    // Only the defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'(dit_pkg::ST_BAD_RANGE))
        else $error("undefined status code");

    // A hit always comes with an ok status.
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'(dit_pkg::ST_OK))
        else $error("hit reported with an error status");

    // Without a hit, the range and tag fields are all zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[dit_pkg::RES_W-1:4] == '0)
        else $error("range fields set without a hit");

endmodule

bind disjoint_interval_table_core dit_checker u_dit_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the disjoint interval table core.
`default_nettype none

module testbench;

    localparam int CLK_HALF   = 10;
    localparam int STALL_MAX  = 17;
    localparam int ITEM_GOAL  = 1400;
    localparam int LONG_HOLD  = 600;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        dit_pkg::status_e          status;
        logic                      hit;
        logic [dit_pkg::VAL_W-1:0] low;
        logic [dit_pkg::VAL_W-1:0] high;
        logic [dit_pkg::TAG_W-1:0] tag;
    } table_answer_t;

    typedef struct packed {
        logic [dit_pkg::VAL_W-1:0] range_first;
        logic [dit_pkg::VAL_W-1:0] range_count;
    } span_t;

    // Mirror of the interval table plus the queue of answers still owed by the block.
    class interval_scoreboard;
        logic [dit_pkg::VAL_W-1:0] slot_low [dit_pkg::CAPACITY];
        logic [dit_pkg::VAL_W-1:0] slot_high[dit_pkg::CAPACITY];
        logic [dit_pkg::TAG_W-1:0] slot_tag [dit_pkg::CAPACITY];
        bit                        slot_used[dit_pkg::CAPACITY];
        int unsigned               used_total;
        table_answer_t             owed_q[$];
        int unsigned               mismatches;
        int unsigned               answers_seen;

        function int lowest_overlap(logic [dit_pkg::VAL_W-1:0] lo,
                                    logic [dit_pkg::VAL_W-1:0] hi);
            int best;
            best = -1;
            for (int k = 0; k < dit_pkg::CAPACITY; k++) begin
                if (slot_used[k] && slot_low[k] <= hi && lo <= slot_high[k]) begin
                    if (best < 0 || slot_low[k] < slot_low[best]) begin
                        best = k;
                    end
                end
            end
            return best;
        endfunction

        function void note_request(logic [1:0] kind, logic [dit_pkg::VAL_W-1:0] range_first,
                                   logic [dit_pkg::VAL_W-1:0] range_count,
                                   logic [dit_pkg::TAG_W-1:0] tag);
            table_answer_t             ans;
            logic [dit_pkg::VAL_W:0]   last_wide;
            logic [dit_pkg::VAL_W-1:0] range_last;
            int                        k;
            ans = '0;
            ans.status = dit_pkg::ST_OK;
            last_wide = {1'b0, range_first} + {1'b0, range_count} - 1'b1;
            range_last = last_wide[dit_pkg::VAL_W-1:0];
            if (range_count == '0 || last_wide[dit_pkg::VAL_W] || kind == dit_pkg::REQ_UNUSED)
            begin
                ans.status = dit_pkg::ST_BAD_RANGE;
            end else begin
                case (kind)
                    dit_pkg::REQ_INSERT: begin
                        if (lowest_overlap(range_first, range_last) >= 0) begin
                            ans.status = dit_pkg::ST_OVERLAP;
                        end else if (used_total >= dit_pkg::CAPACITY) begin
                            ans.status = dit_pkg::ST_FULL;
                        end else begin
                            // The new range lands in the lowest free slot.
                            for (k = 0; k < dit_pkg::CAPACITY; k++) begin
                                if (!slot_used[k]) break;
                            end
                            slot_low[k]  = range_first;
                            slot_high[k] = range_last;
                            slot_tag[k]  = tag;
                            slot_used[k] = 1'b1;
                            used_total++;
                        end
                    end
                    dit_pkg::REQ_REMOVE: begin
                        ans.status = dit_pkg::ST_NOT_FOUND;
                        for (k = 0; k < dit_pkg::CAPACITY; k++) begin
                            if (slot_used[k] && slot_low[k] == range_first
                                    && slot_high[k] == range_last) begin
                                slot_used[k] = 1'b0;
                                used_total--;
                                ans.status = dit_pkg::ST_OK;
                                break;
                            end
                        end
                    end
                    default: begin
                        k = lowest_overlap(range_first, range_last);
                        if (k < 0) begin
                            ans.status = dit_pkg::ST_NOT_FOUND;
                        end else begin
                            ans.hit  = 1'b1;
                            ans.low  = slot_low[k];
                            ans.high = slot_high[k];
                            ans.tag  = slot_tag[k];
                        end
                    end
                endcase
            end
            owed_q.push_back(ans);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [dit_pkg::M_TDATA_W-1:0] word);
            table_answer_t ans;
            answers_seen++;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result %h with no request outstanding", word));
            end else begin
                ans = owed_q.pop_front();
                if (word[2:0] !== ans.status)
                    report_mismatch($sformatf("result %0d status %0d, wanted %s",
                                              answers_seen, word[2:0], ans.status.name()));
                if (word[3] !== ans.hit)
                    report_mismatch($sformatf("result %0d hit %b, wanted %b",
                                              answers_seen, word[3], ans.hit));
                if (word[35:4] !== ans.low)
                    report_mismatch($sformatf("result %0d hit_low %h, wanted %h",
                                              answers_seen, word[35:4], ans.low));
                if (word[67:36] !== ans.high)
                    report_mismatch($sformatf("result %0d hit_high %h, wanted %h",
                                              answers_seen, word[67:36], ans.high));
                if (word[83:68] !== ans.tag)
                    report_mismatch($sformatf("result %0d hit_tag %h, wanted %h",
                                              answers_seen, word[83:68], ans.tag));
            end
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [dit_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [dit_pkg::S_TUSER_W-1:0]  s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [dit_pkg::M_TDATA_W-1:0]  m_tdata;

    interval_scoreboard sb = new;
    bit    sender_calm;
    span_t insert_log[$];

    disjoint_interval_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Entered at a falling edge with s_tvalid low; leaves the same way.
    task automatic send_request(logic [1:0] kind, logic [dit_pkg::VAL_W-1:0] range_first,
                                logic [dit_pkg::VAL_W-1:0] range_count,
                                logic [dit_pkg::TAG_W-1:0] tag);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, STALL_MAX);
        repeat (gap) @(negedge aclk);
        s_tuser  = kind;
        s_tdata  = {tag, range_count, range_first};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, range_first, range_count, tag);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Mostly starts in the lower half of 64-value blocks, so short ranges from different blocks never meet.
    function automatic logic [dit_pkg::VAL_W-1:0] pick_start();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            default: return $urandom_range(0, 255) * 64 + $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [dit_pkg::VAL_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom;
            2:       return $urandom_range(1, 8192);
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    task automatic run_directed();
        send_request(dit_pkg::REQ_SEARCH, 32'd0, 32'hFFFF_FFFF, 16'h0000);
        send_request(dit_pkg::REQ_REMOVE, 32'd5, 32'd1, 16'h0000);
        send_request(dit_pkg::REQ_INSERT, 32'd0, 32'd1, 16'h0000);
        send_request(dit_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'd1, 16'hFFFF);
        send_request(dit_pkg::REQ_INSERT, 32'd100, 32'd0, 16'h00AA);
        send_request(dit_pkg::REQ_INSERT, 32'hFFFF_FFF0, 32'd17, 16'h00AB);
        send_request(dit_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        send_request(dit_pkg::REQ_SEARCH, 32'd0, 32'hFFFF_FFFF, 16'h0000);
        send_request(dit_pkg::REQ_UNUSED, 32'd10, 32'd5, 16'h1111);
        send_request(dit_pkg::REQ_INSERT, 32'h10, 32'd16, 16'h1234);
        send_request(dit_pkg::REQ_INSERT, 32'h18, 32'd2, 16'h4321);
        send_request(dit_pkg::REQ_INSERT, 32'h20, 32'd4, 16'h5555);
        send_request(dit_pkg::REQ_REMOVE, 32'h10, 32'd8, 16'h0000);
        send_request(dit_pkg::REQ_SEARCH, 32'h1F, 32'd2, 16'h0000);
        send_request(dit_pkg::REQ_SEARCH, 32'h1E, 32'hFFFF_FFE2, 16'h0000);
        send_request(dit_pkg::REQ_REMOVE, 32'h10, 32'd16, 16'h0000);
        send_request(dit_pkg::REQ_SEARCH, 32'h10, 32'd16, 16'h0000);
        send_request(dit_pkg::REQ_REMOVE, 32'h10, 32'd16, 16'h0000);
        send_request(dit_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'd1, 16'h0000);
        send_request(dit_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 32'd1, 16'h0000);
        send_request(dit_pkg::REQ_REMOVE, 32'd0, 32'd1, 16'h0000);
        send_request(dit_pkg::REQ_REMOVE, 32'h20, 32'd4, 16'h0000);
    endtask

    task automatic run_random();
        int          sent;
        int          phase;
        int          roll;
        int          pick;
        logic [1:0]  kind;
        logic [31:0] range_first;
        logic [31:0] range_count;
        logic [15:0] tag;
        span_t       span;
        sent = 0;
        while (sent < ITEM_GOAL) begin
            // Phases: 0 fills the table, 1 drains it, 2 mixes everything.
            phase = $urandom_range(0, 2);
            sender_calm = ($urandom_range(0, 3) == 0);
            repeat (80) begin
                roll = $urandom_range(0, 99);
                tag = 16'($urandom_range(0, 65535));
                range_first = pick_start();
                range_count = pick_count();
                if (roll < 8) begin
                    kind = 2'($urandom_range(0, 3));
                    range_first = $urandom;
                    range_count = $urandom;
                end else if (phase == 0) begin
                    kind = (roll < 75) ? dit_pkg::REQ_INSERT :
                           (roll < 90) ? dit_pkg::REQ_SEARCH : dit_pkg::REQ_REMOVE;
                end else if (phase == 1) begin
                    kind = (roll < 60) ? dit_pkg::REQ_REMOVE :
                           (roll < 80) ? dit_pkg::REQ_SEARCH : dit_pkg::REQ_INSERT;
                end else begin
                    kind = (roll < 40) ? dit_pkg::REQ_INSERT :
                           (roll < 70) ? dit_pkg::REQ_SEARCH : dit_pkg::REQ_REMOVE;
                end
                if (roll >= 8 && kind == dit_pkg::REQ_INSERT) begin
                    span.range_first = range_first;
                    span.range_count = range_count;
                    insert_log.push_back(span);
                    if (insert_log.size() > 160) void'(insert_log.pop_front());
                end else if (roll >= 8 && kind == dit_pkg::REQ_REMOVE && insert_log.size() > 0
                             && $urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, insert_log.size() - 1);
                    range_first = insert_log[pick].range_first;
                    range_count = insert_log[pick].range_count;
                    insert_log.delete(pick);
                    // Now and then a remove that only overlaps a stored range.
                    if ($urandom_range(0, 4) == 0) range_count = range_count + 1;
                end
                send_request(kind, range_first, range_count, tag);
                sent++;
            end
        end
    endtask

    // Result side: random hold-offs, calm stretches, and two long stalls to back up the input.
    initial begin
        int  gap;
        bit  calm;
        m_tready = 1'b0;
        calm = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (sb.answers_seen % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, STALL_MAX);
            if (sb.answers_seen == 300 || sb.answers_seen == 900) gap = LONG_HOLD;
            m_tready = 1'b0;
            repeat (gap) @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        sender_calm = 1'b0;
        aresetn  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        run_directed();
        run_random();
        while (sb.owed_q.size() != 0) @(posedge aclk);
        // Room for a stray late result to show up.
        repeat (2 * dit_pkg::CAPACITY + 8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
